// ===== hdl/greedy_word_wrap_line_breaker_defines.svh =====
// assertion macros for the greedy word wrap line breaker checker
// no dependencies; expects aclk and aresetn in the scope of use
`ifndef GREEDY_WORD_WRAP_LINE_BREAKER_DEFINES_SVH
`define GREEDY_WORD_WRAP_LINE_BREAKER_DEFINES_SVH

// check that is off while reset is asserted
`define GWWLB_ASSERT(name, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("gwwlb port check failed");

// check that also holds across reset
`define GWWLB_ASSERT_RST(name, prop) \
    name: assert property (@(posedge aclk) prop) \
        else $error("gwwlb reset check failed");

`endif

// ===== hdl/gwwlb_pkg.sv =====
// shared constants and types for the greedy word wrap line breaker
// no dependencies
package gwwlb_pkg;

    localparam int CHAR_W    = 8;
    localparam int WIDTH_W   = 8;
    localparam int MAX_TEXT  = 1024;
    localparam int POS_W     = $clog2(MAX_TEXT);
    localparam int MAX_LINES = 27;
    localparam int CNT_W     = 5;

    localparam logic [POS_W-1:0]   POS_TOP     = POS_W'(MAX_TEXT - 1);
    localparam logic [CNT_W-1:0]   LINE_CAP    = CNT_W'(MAX_LINES);
    localparam logic [WIDTH_W-1:0] WRAP_RESET  = 8'd38;

    localparam logic [CHAR_W-1:0]  CH_END      = 8'd0;
    localparam logic [CHAR_W-1:0]  CH_FORCE    = 8'd64;
    localparam logic [CHAR_W-1:0]  CH_SPACE    = 8'd32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // character class as decided by the front end
    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_SPACE = 2'd1,
        KIND_FORCE = 2'd2,
        KIND_END   = 2'd3
    } kind_t;

    // one classified item travelling between front, queue and back
    typedef struct packed {
        logic  valid;
        kind_t kind;
    } qitem_t;

endpackage

// ===== hdl/gwwlb_front.sv =====
// front end: input register and character classifier
// depends on gwwlb_pkg
module gwwlb_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [gwwlb_pkg::CHAR_W-1:0] s_character,
    output gwwlb_pkg::qitem_t            push_item,
    input  logic                         q_full
);
    import gwwlb_pkg::*;

    logic  front_valid_reg;
    logic  front_valid_next;
    kind_t front_kind_reg;
    kind_t kind_in;

    // classify the incoming character
    always_comb begin
        unique case (s_character)
            CH_END:   kind_in = KIND_END;
            CH_FORCE: kind_in = KIND_FORCE;
            CH_SPACE: kind_in = KIND_SPACE;
            default:  kind_in = KIND_OTHER;
        endcase
    end

    // stage is free when empty or draining into the queue this cycle
    assign s_ready = !front_valid_reg || !q_full;

    always_comb begin
        front_valid_next = front_valid_reg;
        if (s_valid && s_ready) begin
            front_valid_next = 1'b1;
        end else if (front_valid_reg && !q_full) begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else begin
            front_valid_reg <= front_valid_next;
        end
    end

    // payload register
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            front_kind_reg <= kind_in;
        end
    end

    assign push_item.valid = front_valid_reg;
    assign push_item.kind  = front_kind_reg;

endmodule

// ===== hdl/gwwlb_queue.sv =====
// small queue of classified items between front and back
// depends on gwwlb_pkg
module gwwlb_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  gwwlb_pkg::qitem_t push_item,
    output logic              q_full,
    output gwwlb_pkg::qitem_t head_item,
    input  logic              pop
);
    import gwwlb_pkg::*;

    kind_t               q_mem [QUEUE_DEPTH];
    logic [QUEUE_AW:0]   wr_ptr_reg;
    logic [QUEUE_AW:0]   wr_ptr_next;
    logic [QUEUE_AW:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]   rd_ptr_next;
    logic                q_empty;
    logic                push;

    // wrap bit differs and index matches when full
    assign q_empty = (wr_ptr_reg == rd_ptr_reg);
    assign q_full  = (wr_ptr_reg[QUEUE_AW] != rd_ptr_reg[QUEUE_AW]) &&
                     (wr_ptr_reg[QUEUE_AW-1:0] == rd_ptr_reg[QUEUE_AW-1:0]);
    assign push    = push_item.valid && !q_full;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop && !q_empty) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg[QUEUE_AW-1:0]] <= push_item.kind;
        end
    end

    assign head_item.valid = !q_empty;
    assign head_item.kind  = q_mem[rd_ptr_reg[QUEUE_AW-1:0]];

endmodule

// ===== hdl/gwwlb_back.sv =====
// back end: line tracking state and output record register
// depends on gwwlb_pkg
module gwwlb_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [gwwlb_pkg::WIDTH_W-1:0] wrap_width,
    input  gwwlb_pkg::qitem_t             head_item,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gwwlb_pkg::POS_W-1:0]   m_line_start,
    output logic [gwwlb_pkg::POS_W-1:0]   m_line_end,
    output logic                          m_final_line,
    output logic                          m_capped
);
    import gwwlb_pkg::*;

    logic [POS_W-1:0] position_reg,   position_next;
    logic [POS_W-1:0] start_pos_reg,  start_pos_next;
    logic [POS_W-1:0] space_pos_reg,  space_pos_next;
    logic             space_seen_reg, space_seen_next;
    logic [CNT_W-1:0] line_count_reg, line_count_next;
    logic             halted_reg,     halted_next;
    logic             m_valid_reg,    m_valid_next;

    logic [POS_W-1:0] line_start_reg, line_end_reg;
    logic             final_line_reg, capped_reg;

    logic [POS_W-1:0] line_len;
    logic [POS_W-1:0] break_pos;
    logic [CNT_W-1:0] count_inc;
    logic             is_end, is_force, is_space;
    logic             do_break, hard, cap, emit;

    // take the head item once the output slot is free
    assign pop = head_item.valid && (!m_valid_reg || m_ready);

    assign is_end   = (head_item.kind == KIND_END);
    assign is_force = (head_item.kind == KIND_FORCE);
    assign is_space = (head_item.kind == KIND_SPACE);

    // break decision
    assign line_len  = (position_reg >= start_pos_reg) ? position_reg - start_pos_reg : '0;
    assign do_break  = (line_len >= POS_W'(wrap_width)) || is_force || is_end;
    assign hard      = is_force || is_end || !space_seen_reg;
    assign break_pos = hard ? position_reg : space_pos_reg;
    assign count_inc = line_count_reg + 1'b1;
    assign cap       = (count_inc == LINE_CAP);
    assign emit      = pop && !halted_reg && do_break;

    // state update for one item
    always_comb begin
        position_next   = position_reg;
        start_pos_next  = start_pos_reg;
        space_pos_next  = space_pos_reg;
        space_seen_next = space_seen_reg;
        line_count_next = line_count_reg;
        halted_next     = halted_reg;
        if (pop) begin
            if (halted_reg) begin
                if (is_end) begin
                    position_next   = '0;
                    start_pos_next  = '0;
                    space_pos_next  = '0;
                    space_seen_next = 1'b0;
                    line_count_next = '0;
                    halted_next     = 1'b0;
                end
            end else if (do_break && cap) begin
                line_count_next = count_inc;
                if (is_end) begin
                    position_next   = '0;
                    start_pos_next  = '0;
                    space_pos_next  = '0;
                    space_seen_next = 1'b0;
                    line_count_next = '0;
                end else begin
                    halted_next = 1'b1;
                end
            end else begin
                if (do_break) begin
                    line_count_next = count_inc;
                    space_seen_next = 1'b0;
                    if (is_force || space_seen_reg) begin
                        start_pos_next = (break_pos == POS_TOP) ? POS_TOP : break_pos + 1'b1;
                    end else begin
                        start_pos_next = break_pos;
                    end
                end
                if (is_space) begin
                    space_pos_next  = position_reg;
                    space_seen_next = 1'b1;
                end
                if (is_end) begin
                    position_next   = '0;
                    start_pos_next  = '0;
                    space_pos_next  = '0;
                    space_seen_next = 1'b0;
                    line_count_next = '0;
                end else if (position_reg != POS_TOP) begin
                    position_next = position_reg + 1'b1;
                end
            end
        end
    end

    // output slot control
    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg   <= '0;
            start_pos_reg  <= '0;
            space_pos_reg  <= '0;
            space_seen_reg <= 1'b0;
            line_count_reg <= '0;
            halted_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            position_reg   <= position_next;
            start_pos_reg  <= start_pos_next;
            space_pos_reg  <= space_pos_next;
            space_seen_reg <= space_seen_next;
            line_count_reg <= line_count_next;
            halted_reg     <= halted_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // record payload
    always_ff @(posedge aclk) begin
        if (emit) begin
            line_start_reg <= start_pos_reg;
            line_end_reg   <= break_pos;
            final_line_reg <= is_end || cap;
            capped_reg     <= cap;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_line_start = line_start_reg;
    assign m_line_end   = line_end_reg;
    assign m_final_line = final_line_reg;
    assign m_capped     = capped_reg;

endmodule

// ===== hdl/greedy_word_wrap_line_breaker.sv =====
// Greedy word wrap line breaker: takes one message character per item and
// returns a line record (start, one-past-end, final and cap flags) whenever a
// line breaks on width, on '@', or on the NUL terminator. It sustains one item
// per clock while no record waits on m_ready; the back end updates its line
// state once per cycle and that state loop sets the rate. A record's path runs
// through the input register, then the queue, then the output register; a
// four-entry queue lets input flow while a record waits on m_ready. Users must
// write wrap_width via cfg_wr_en/cfg_wr_data only while idle (not enforced).
// top level: wires front, queue and back, holds the width register
// depends on gwwlb_pkg, gwwlb_front, gwwlb_queue, gwwlb_back
module greedy_word_wrap_line_breaker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [gwwlb_pkg::WIDTH_W-1:0] cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [gwwlb_pkg::CHAR_W-1:0]  s_character,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gwwlb_pkg::POS_W-1:0]   m_line_start,
    output logic [gwwlb_pkg::POS_W-1:0]   m_line_end,
    output logic                          m_final_line,
    output logic                          m_capped
);
    import gwwlb_pkg::*;

    logic [WIDTH_W-1:0] wrap_width_reg;
    qitem_t             push_item;
    qitem_t             head_item;
    logic               q_full;
    logic               pop;

    // width register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrap_width_reg <= WRAP_RESET;
        end else if (cfg_wr_en) begin
            wrap_width_reg <= cfg_wr_data;
        end
    end

    gwwlb_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_character (s_character),
        .push_item   (push_item),
        .q_full      (q_full)
    );

    gwwlb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_item (push_item),
        .q_full    (q_full),
        .head_item (head_item),
        .pop       (pop)
    );

    gwwlb_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .wrap_width   (wrap_width_reg),
        .head_item    (head_item),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_line_start (m_line_start),
        .m_line_end   (m_line_end),
        .m_final_line (m_final_line),
        .m_capped     (m_capped)
    );

endmodule

// ===== hdl/gwwlb_checker.sv =====
// port level checks for the line breaker, bound to the top level
// depends on gwwlb_pkg and greedy_word_wrap_line_breaker_defines.svh
`include "greedy_word_wrap_line_breaker_defines.svh"

module gwwlb_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [gwwlb_pkg::CHAR_W-1:0]  s_character,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [gwwlb_pkg::POS_W-1:0]   m_line_start,
    input logic [gwwlb_pkg::POS_W-1:0]   m_line_end,
    input logic                          m_final_line,
    input logic                          m_capped
);
    import gwwlb_pkg::*;

    logic [2*POS_W+1:0] out_word;

    // all result fields side by side
    assign out_word = {m_line_start, m_line_end, m_final_line, m_capped};

    // a waiting input item keeps its character
    `GWWLB_ASSERT(a_in_hold, s_valid && !s_ready |=> s_valid && $stable(s_character))

    // a stalled record keeps its fields
    `GWWLB_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(out_word))

    // reset empties the output slot
    `GWWLB_ASSERT_RST(a_rst_empty, !aresetn |=> !m_valid)

    // a capped record always closes the message
    `GWWLB_ASSERT(a_cap_final, m_valid && m_capped |-> m_final_line)

    // a line never ends before it starts
    `GWWLB_ASSERT(a_line_order, m_valid |-> m_line_end >= m_line_start)

endmodule

bind greedy_word_wrap_line_breaker gwwlb_checker u_gwwlb_checker (.*);
